// ----- rtl/bmt_pkg.sv -----
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared codes, state type and control structs of the bounded message table.
// ----------------------------------------------------------------------------
package bmt_pkg;

    // Fixed payload widths.
    localparam int ID_W     = 64;
    localparam int ORDER_W  = 64;
    localparam int IN_DIG_W = 32;
    localparam int LIMIT_W  = 5;
    localparam int CFG_IDX_W = 2;

    // Operation codes.
    localparam logic [1:0] OP_INS_RX    = 2'd0;
    localparam logic [1:0] OP_INS_LOCAL = 2'd1;
    localparam logic [1:0] OP_MARK_BC   = 2'd2;
    localparam logic [1:0] OP_MARK_FAIL = 2'd3;

    // Delivery states of a local entry.
    localparam logic [1:0] DL_QUEUED    = 2'd0;
    localparam logic [1:0] DL_BROADCAST = 2'd1;
    localparam logic [1:0] DL_FAILED    = 2'd2;

    // Result status codes.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_DUP       = 4'd1;
    localparam logic [3:0] ST_CONFLICT  = 4'd2;
    localparam logic [3:0] ST_QFULL     = 4'd3;
    localparam logic [3:0] ST_EXHAUSTED = 4'd4;
    localparam logic [3:0] ST_FULL      = 4'd5;
    localparam logic [3:0] ST_NOTFOUND  = 4'd6;
    localparam logic [3:0] ST_NOTLOCAL  = 4'd7;
    localparam logic [3:0] ST_BADSTATE  = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUED_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ORDER  = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic shift;
        logic write;
        logic respond;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic evict;
        logic do_write;
        logic shift_done;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/bmt_if.sv -----
// ----------------------------------------------------------------------------
// bmt_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface bmt_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [bmt_pkg::ID_W-1:0]    msg_id;
    logic [bmt_pkg::IN_DIG_W-1:0] payload_digest;
    logic                        has_parent;
    logic [bmt_pkg::ID_W-1:0]    parent_id;
    logic [1:0]                  init_state;

    modport source (output valid, operation, msg_id, payload_digest, has_parent,
                    parent_id, init_state, input ready);
    modport sink (input valid, operation, msg_id, payload_digest, has_parent,
                  parent_id, init_state, output ready);
endinterface

interface bmt_out_if;
    logic                          valid;
    logic                          ready;
    logic [3:0]                    status;
    logic                          evicted_valid;
    logic [bmt_pkg::ID_W-1:0]      evicted_id;
    logic                          order_valid;
    logic [bmt_pkg::ORDER_W-1:0]   assigned_order;

    modport source (output valid, status, evicted_valid, evicted_id, order_valid,
                    assigned_order, input ready);
    modport sink (input valid, status, evicted_valid, evicted_id, order_valid,
                  assigned_order, output ready);
endinterface

interface bmt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmt_pkg::CFG_IDX_W-1:0]   index;
    logic [63:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bmt_ram.sv -----
// ----------------------------------------------------------------------------
// bmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmt_ctrl
// Sequencer of one operation: lookup scan, decision, shift, write, response.
// ----------------------------------------------------------------------------
module bmt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bmt_pkg::sts_t sts,
    output bmt_pkg::cmd_t cmd
);

    bmt_pkg::state_t state_reg;
    bmt_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bmt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bmt_pkg::S_SCAN;
                end
            end
            bmt_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = bmt_pkg::S_DECIDE;
                end
            end
            bmt_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.evict)
                begin
                    state_next = bmt_pkg::S_SHIFT;
                end
                else if (sts.do_write)
                begin
                    state_next = bmt_pkg::S_WRITE;
                end
                else
                begin
                    state_next = bmt_pkg::S_DONE;
                end
            end
            bmt_pkg::S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = bmt_pkg::S_WRITE;
                end
            end
            bmt_pkg::S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = bmt_pkg::S_DONE;
            end
            bmt_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = bmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bmt_dp.sv -----
// ----------------------------------------------------------------------------
// bmt_dp
// Datapath: configuration, entry RAM, scan and shift pointers, decision logic
// and the result register.
// ----------------------------------------------------------------------------
module bmt_dp #(
    parameter int MAX_ENTRIES = 16,
    parameter int DIGEST_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bmt_pkg::cmd_t                     cmd,
    output bmt_pkg::sts_t                     sts,
    // Configuration write.
    input  logic                              cfg_we,
    input  logic [bmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data,
    // Input item.
    input  logic [1:0]                        operation,
    input  logic [bmt_pkg::ID_W-1:0]          msg_id,
    input  logic [bmt_pkg::IN_DIG_W-1:0]      payload_digest,
    input  logic                              has_parent,
    input  logic [bmt_pkg::ID_W-1:0]          parent_id,
    input  logic [1:0]                        init_state,
    // Result item.
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [3:0]                        status,
    output logic                              evicted_valid,
    output logic [bmt_pkg::ID_W-1:0]          evicted_id,
    output logic                              order_valid,
    output logic [bmt_pkg::ORDER_W-1:0]       assigned_order
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (NW > bmt_pkg::LIMIT_W) ? NW : bmt_pkg::LIMIT_W;
    localparam int ID_W = bmt_pkg::ID_W;
    localparam int DW = ID_W + DIGEST_BITS + 3;
    localparam int DIG_LO = 3;

    // Configuration and persistent state.
    logic [bmt_pkg::LIMIT_W-1:0] capacity_reg;
    logic [bmt_pkg::LIMIT_W-1:0] qlimit_reg;
    logic [bmt_pkg::ORDER_W-1:0] last_order_reg;
    logic [bmt_pkg::LIMIT_W-1:0] queued_reg;
    logic [NW-1:0]               fill_reg;

    // Latched item.
    logic [1:0]             op_reg;
    logic [ID_W-1:0]        id_reg;
    logic [DIGEST_BITS-1:0] dig_reg;
    logic                   hp_reg;
    logic [ID_W-1:0]        par_reg;
    logic [1:0]             init_reg;

    // Scan and shift pointers.
    logic [NW-1:0] scan_idx_reg;
    logic [NW-1:0] sh_rd_reg;
    logic          pend_reg;
    logic [AW-1:0] pidx_reg;

    // Lookup and victim results.
    logic                   found_reg;
    logic [AW-1:0]          k_reg;
    logic [DIGEST_BITS-1:0] k_dig_reg;
    logic                   k_local_reg;
    logic [1:0]             k_deliv_reg;
    logic                   vic_reg;
    logic [AW-1:0]          v_reg;
    logic [ID_W-1:0]        v_id_reg;

    // Decision registers.
    logic                        evict_reg;
    logic [3:0]                  st_reg;
    logic                        ev_valid_reg;
    logic [ID_W-1:0]             ev_id_reg;
    logic                        ord_valid_reg;

    // Output register.
    logic                        out_valid_reg;
    logic [3:0]                  out_st_reg;
    logic                        out_ev_valid_reg;
    logic [ID_W-1:0]             out_ev_id_reg;
    logic                        out_ord_valid_reg;
    logic [bmt_pkg::ORDER_W-1:0] out_ord_reg;

    // RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [ID_W-1:0]        r_id;
    logic [DIGEST_BITS-1:0] r_dig;
    logic                   r_local;
    logic [1:0]             r_deliv;
    logic [63:0]            dig_ext;

    // Decision signals.
    logic [CW-1:0]  cap_ext;
    logic [CW-1:0]  eff_cap;
    logic [CW-1:0]  qlim_ext;
    logic [CW-1:0]  qcap;
    logic           is_ins;
    logic           is_local;
    logic           is_full;
    logic           exhausted;
    logic [1:0]     target;
    logic [3:0]     st_c;
    logic           evict_c;
    logic           write_c;
    logic           ins_ok_c;
    logic           pin;

    bmt_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry fields of the read data.
    assign r_id    = ram_rdata[DW-1 -: ID_W];
    assign r_dig   = ram_rdata[DIG_LO +: DIGEST_BITS];
    assign r_local = ram_rdata[2];
    assign r_deliv = ram_rdata[1:0];
    assign dig_ext = {{(64 - bmt_pkg::IN_DIG_W){1'b0}}, payload_digest};

    // Effective capacity and queued cap.
    assign cap_ext  = CW'(capacity_reg);
    assign qlim_ext = CW'(qlimit_reg);
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_ext > CW'(MAX_ENTRIES))
        begin
            eff_cap = CW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        qcap = (qlim_ext < (eff_cap - CW'(1))) ? qlim_ext : (eff_cap - CW'(1));
    end

    assign is_ins    = (op_reg == bmt_pkg::OP_INS_RX) || (op_reg == bmt_pkg::OP_INS_LOCAL);
    assign is_local  = (op_reg == bmt_pkg::OP_INS_LOCAL);
    assign pin       = is_local && hp_reg;
    assign is_full   = CW'(fill_reg) >= eff_cap;
    assign exhausted = &last_order_reg;
    assign target    = (op_reg == bmt_pkg::OP_MARK_BC) ? bmt_pkg::DL_BROADCAST
                                                       : bmt_pkg::DL_FAILED;

    // Decision on the lookup and victim results.
    always_comb
    begin
        st_c     = bmt_pkg::ST_OK;
        evict_c  = 1'b0;
        write_c  = 1'b0;
        ins_ok_c = 1'b0;
        if (is_ins)
        begin
            if (found_reg)
            begin
                st_c = (k_dig_reg == dig_reg) ? bmt_pkg::ST_DUP : bmt_pkg::ST_CONFLICT;
            end
            else if (is_local && (init_reg == 2'd3))
            begin
                st_c = bmt_pkg::ST_BADSTATE;
            end
            else if (is_local && (init_reg == bmt_pkg::DL_QUEUED)
                     && (CW'(queued_reg) >= qcap))
            begin
                st_c = bmt_pkg::ST_QFULL;
            end
            else if (exhausted)
            begin
                st_c = bmt_pkg::ST_EXHAUSTED;
            end
            else if (is_full && !vic_reg)
            begin
                st_c = bmt_pkg::ST_FULL;
            end
            else
            begin
                ins_ok_c = 1'b1;
                write_c  = 1'b1;
                evict_c  = is_full;
            end
        end
        else
        begin
            if (!found_reg)
            begin
                st_c = bmt_pkg::ST_NOTFOUND;
            end
            else if (!k_local_reg)
            begin
                st_c = bmt_pkg::ST_NOTLOCAL;
            end
            else if (k_deliv_reg == target)
            begin
                st_c = bmt_pkg::ST_OK;
            end
            else if (k_deliv_reg != bmt_pkg::DL_QUEUED)
            begin
                st_c = bmt_pkg::ST_BADSTATE;
            end
            else
            begin
                write_c = 1'b1;
            end
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts.scan_done  = (scan_idx_reg == fill_reg) && !pend_reg;
        sts.evict      = evict_c;
        sts.do_write   = write_c;
        sts.shift_done = (sh_rd_reg == fill_reg) && !pend_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // RAM read address and write port.
    always_comb
    begin
        ram_raddr = cmd.scan ? scan_idx_reg[AW-1:0] : sh_rd_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = pidx_reg - AW'(1);
        ram_wdata = ram_rdata;
        if (cmd.shift && pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.write)
        begin
            ram_we = 1'b1;
            if (is_ins)
            begin
                ram_waddr = evict_reg ? AW'(fill_reg - NW'(1)) : AW'(fill_reg);
                ram_wdata = {id_reg, dig_reg, is_local,
                             is_local ? init_reg : bmt_pkg::DL_QUEUED};
            end
            else
            begin
                ram_waddr = k_reg;
                ram_wdata = {id_reg, k_dig_reg, 1'b1, target};
            end
        end
    end

    // Control state: configuration, fill, queued count, pointers, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= bmt_pkg::LIMIT_W'(16);
            qlimit_reg     <= bmt_pkg::LIMIT_W'(4);
            last_order_reg <= '0;
            queued_reg     <= '0;
            fill_reg       <= '0;
            scan_idx_reg   <= '0;
            sh_rd_reg      <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            vic_reg        <= 1'b0;
            evict_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bmt_pkg::CFG_CAPACITY:     capacity_reg   <= cfg_data[bmt_pkg::LIMIT_W-1:0];
                    bmt_pkg::CFG_QUEUED_LIMIT: qlimit_reg     <= cfg_data[bmt_pkg::LIMIT_W-1:0];
                    bmt_pkg::CFG_START_ORDER:  last_order_reg <= cfg_data;
                    default: ;
                endcase
            end

            // New item: restart the scan.
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                pend_reg     <= 1'b0;
                found_reg    <= 1'b0;
                vic_reg      <= 1'b0;
            end

            // Lookup and victim scan, one entry per cycle.
            if (cmd.scan)
            begin
                if (scan_idx_reg < fill_reg)
                begin
                    pend_reg     <= 1'b1;
                    scan_idx_reg <= scan_idx_reg + NW'(1);
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg)
                begin
                    if (!found_reg && (r_id == id_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!vic_reg && !(pin && (r_id == par_reg))
                        && !(r_local && (r_deliv == bmt_pkg::DL_QUEUED)))
                    begin
                        vic_reg <= 1'b1;
                    end
                end
            end

            // Decision: bump the order, retire a queued mark.
            if (cmd.decide)
            begin
                evict_reg <= evict_c;
                sh_rd_reg <= NW'(v_reg) + NW'(1);
                if (ins_ok_c)
                begin
                    last_order_reg <= last_order_reg + 64'd1;
                end
                if (!is_ins && write_c && (queued_reg != '0))
                begin
                    queued_reg <= queued_reg - bmt_pkg::LIMIT_W'(1);
                end
            end

            // Shift the younger entries down over the victim.
            if (cmd.shift)
            begin
                if (sh_rd_reg < fill_reg)
                begin
                    pend_reg  <= 1'b1;
                    sh_rd_reg <= sh_rd_reg + NW'(1);
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end

            // Append the new entry.
            if (cmd.write && is_ins)
            begin
                if (!evict_reg)
                begin
                    fill_reg <= fill_reg + NW'(1);
                end
                if (is_local && (init_reg == bmt_pkg::DL_QUEUED))
                begin
                    queued_reg <= queued_reg + bmt_pkg::LIMIT_W'(1);
                end
            end

            // Result transfer.
            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            id_reg   <= msg_id;
            dig_reg  <= dig_ext[DIGEST_BITS-1:0];
            hp_reg   <= has_parent;
            par_reg  <= parent_id;
            init_reg <= init_state;
        end
        if ((cmd.scan || cmd.shift) && (scan_idx_reg < fill_reg || sh_rd_reg < fill_reg))
        begin
            pidx_reg <= ram_raddr;
        end
        if (cmd.scan && pend_reg)
        begin
            if (!found_reg && (r_id == id_reg))
            begin
                k_reg       <= pidx_reg;
                k_dig_reg   <= r_dig;
                k_local_reg <= r_local;
                k_deliv_reg <= r_deliv;
            end
            if (!vic_reg && !(pin && (r_id == par_reg))
                && !(r_local && (r_deliv == bmt_pkg::DL_QUEUED)))
            begin
                v_reg    <= pidx_reg;
                v_id_reg <= r_id;
            end
        end
        if (cmd.decide)
        begin
            st_reg        <= st_c;
            ev_valid_reg  <= evict_c;
            ev_id_reg     <= evict_c ? v_id_reg : '0;
            ord_valid_reg <= ins_ok_c;
        end
        if (cmd.respond)
        begin
            out_st_reg        <= st_reg;
            out_ev_valid_reg  <= ev_valid_reg;
            out_ev_id_reg     <= ev_id_reg;
            out_ord_valid_reg <= ord_valid_reg;
            out_ord_reg       <= ord_valid_reg ? last_order_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign evicted_valid  = out_ev_valid_reg;
    assign evicted_id     = out_ev_id_reg;
    assign order_valid    = out_ord_valid_reg;
    assign assigned_order = out_ord_reg;

`ifndef SYNTHESIS
    // The fill never exceeds the table depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NW'(MAX_ENTRIES))
        else $error("fill count above table depth");

    // An eviction is only ever reported with a successful insert.
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && evict_c |-> ins_ok_c && is_full)
        else $error("eviction without successful insert into a full table");

    // The fill grows only on a write that evicted nothing.
    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) && !$past(cmd.load) |->
        $past(cmd.write) && $past(is_ins) && !$past(evict_reg))
        else $error("fill changed outside an appending write");
`endif

endmodule

// ----- rtl/bounded_message_table_with_pinning_top.sv -----
// ----------------------------------------------------------------------------
// bounded_message_table_with_pinning_top
// Bounded insertion-ordered message table with eviction pinning.
// ----------------------------------------------------------------------------
// One operation is handled at a time. An item passes through these steps in
// order: a scan of every entry through the single read port of the entry RAM
// for the id lookup and the eviction victim, a decision, a move of the younger
// entries down over an evicted one, a write, loading the result register and
// a return to idle to take the next item. Only an insert that evicts runs the
// shift, and only an operation that changes the table runs the write. A
// finished result waits in the result register while the next item is taken;
// the block stalls before loading a new result while that register is still
// occupied and not being read.
module bounded_message_table_with_pinning_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int DIGEST_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bmt_in_if.sink     in_ch,
    bmt_out_if.source  out_ch,
    bmt_cfg_if.sink    cfg_ch
);

    bmt_pkg::cmd_t cmd;
    bmt_pkg::sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ch.ready = 1'b1;

    bmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIGEST_BITS (DIGEST_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_ch.valid),
        .cfg_index      (cfg_ch.index),
        .cfg_data       (cfg_ch.data),
        .operation      (in_ch.operation),
        .msg_id         (in_ch.msg_id),
        .payload_digest (in_ch.payload_digest),
        .has_parent     (in_ch.has_parent),
        .parent_id      (in_ch.parent_id),
        .init_state     (in_ch.init_state),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .status         (out_ch.status),
        .evicted_valid  (out_ch.evicted_valid),
        .evicted_id     (out_ch.evicted_id),
        .order_valid    (out_ch.order_valid),
        .assigned_order (out_ch.assigned_order)
    );

endmodule

// ----- dv/bmt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_checker
// Watches the item, result and configuration channels of the message table,
// predicts each result from its own model of the table and compares it.
// ----------------------------------------------------------------------------
module bmt_checker (
    input  logic       clk,
    input  logic       rst_n,
    bmt_in_if.sink     in_ch,
    bmt_out_if.sink    out_ch,
    bmt_cfg_if.sink    cfg_ch,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [3:0]  status;
        logic        ev_valid;
        logic [63:0] ev_id;
        logic        ord_valid;
        logic [63:0] ord;
    } table_result_t;

    // Model state of the table.
    logic [4:0]  cap_reg;
    logic [4:0]  qlimit_reg;
    logic [63:0] last_ord;
    int          queued_cnt;
    int          fill;
    logic [63:0] t_id [16];
    logic [31:0] t_dig [16];
    logic        t_local [16];
    logic [1:0]  t_dl [16];

    table_result_t expected_results[$];
    int            errors;
    int            result_count;

    assign fail_count = errors;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        errors++;
    endtask

    function automatic bit is_queued_entry(int i);
        return t_local[i] && t_dl[i] == bmt_pkg::DL_QUEUED;
    endfunction

    // Apply one operation to the model table and return its result.
    function automatic table_result_t apply_operation(logic [1:0] op, logic [63:0] id,
                                                      logic [31:0] dig, logic hp,
                                                      logic [63:0] par, logic [1:0] init);
        table_result_t r;
        int cap;
        int hit;
        int vic;
        int qcap;
        bit is_local;
        bit pin;
        logic [1:0] target;
        r = '0;
        cap = (cap_reg == 0) ? 1 : (cap_reg > 16 ? 16 : int'(cap_reg));
        hit = -1;
        for (int i = fill - 1; i >= 0; i--)
            if (t_id[i] == id) hit = i;
        if (op == bmt_pkg::OP_INS_RX || op == bmt_pkg::OP_INS_LOCAL) begin
            is_local = (op == bmt_pkg::OP_INS_LOCAL);
            pin = is_local && hp;
            qcap = (int'(qlimit_reg) < cap - 1) ? int'(qlimit_reg) : cap - 1;
            vic = -1;
            if (hit >= 0)
                r.status = (t_dig[hit] == dig) ? bmt_pkg::ST_DUP : bmt_pkg::ST_CONFLICT;
            else if (is_local && init > bmt_pkg::DL_FAILED)
                r.status = bmt_pkg::ST_BADSTATE;
            else if (is_local && init == bmt_pkg::DL_QUEUED && queued_cnt >= qcap)
                r.status = bmt_pkg::ST_QFULL;
            else if (last_ord == '1)
                r.status = bmt_pkg::ST_EXHAUSTED;
            else begin
                if (fill >= cap) begin
                    for (int i = 0; i < fill && vic < 0; i++)
                        if (!(pin && t_id[i] == par) && !is_queued_entry(i))
                            vic = i;
                end
                if (fill >= cap && vic < 0)
                    r.status = bmt_pkg::ST_FULL;
                else begin
                    if (vic >= 0) begin
                        r.ev_valid = 1'b1;
                        r.ev_id = t_id[vic];
                        if (is_queued_entry(vic) && queued_cnt > 0)
                            queued_cnt--;
                        for (int i = vic; i + 1 < fill; i++) begin
                            t_id[i] = t_id[i + 1];
                            t_dig[i] = t_dig[i + 1];
                            t_local[i] = t_local[i + 1];
                            t_dl[i] = t_dl[i + 1];
                        end
                        fill--;
                    end
                    last_ord = last_ord + 1;
                    t_id[fill] = id;
                    t_dig[fill] = dig;
                    t_local[fill] = is_local;
                    t_dl[fill] = is_local ? init : bmt_pkg::DL_QUEUED;
                    if (is_local && init == bmt_pkg::DL_QUEUED)
                        queued_cnt++;
                    fill++;
                    r.ord_valid = 1'b1;
                    r.ord = last_ord;
                end
            end
        end
        else begin
            target = (op == bmt_pkg::OP_MARK_BC) ? bmt_pkg::DL_BROADCAST : bmt_pkg::DL_FAILED;
            if (hit < 0)
                r.status = bmt_pkg::ST_NOTFOUND;
            else if (!t_local[hit])
                r.status = bmt_pkg::ST_NOTLOCAL;
            else if (t_dl[hit] == target)
                r.status = bmt_pkg::ST_OK;
            else if (t_dl[hit] != bmt_pkg::DL_QUEUED)
                r.status = bmt_pkg::ST_BADSTATE;
            else begin
                t_dl[hit] = target;
                if (queued_cnt > 0)
                    queued_cnt--;
            end
        end
        return r;
    endfunction

    // Track configuration, predict on each item transfer, check each result.
    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n) begin
            cap_reg = 5'd16;
            qlimit_reg = 5'd4;
            last_ord = '0;
            queued_cnt = 0;
            fill = 0;
            errors = 0;
            result_count = 0;
            expected_results.delete();
            pending = 0;
        end
        else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    bmt_pkg::CFG_CAPACITY:     cap_reg = cfg_ch.data[4:0];
                    bmt_pkg::CFG_QUEUED_LIMIT: qlimit_reg = cfg_ch.data[4:0];
                    bmt_pkg::CFG_START_ORDER:  last_ord = cfg_ch.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("result %0d arrived with nothing expected", result_count);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (out_ch.status !== want.status)
                        report("status", 64'(out_ch.status), 64'(want.status));
                    if (out_ch.evicted_valid !== want.ev_valid)
                        report("evicted_valid", 64'(out_ch.evicted_valid), 64'(want.ev_valid));
                    if (out_ch.evicted_id !== want.ev_id)
                        report("evicted_id", out_ch.evicted_id, want.ev_id);
                    if (out_ch.order_valid !== want.ord_valid)
                        report("order_valid", 64'(out_ch.order_valid), 64'(want.ord_valid));
                    if (out_ch.assigned_order !== want.ord)
                        report("assigned_order", out_ch.assigned_order, want.ord);
                end
                result_count++;
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.insert(expected_results.size(),
                    apply_operation(in_ch.operation, in_ch.msg_id,
                        in_ch.payload_digest, in_ch.has_parent, in_ch.parent_id,
                        in_ch.init_state));
            pending = expected_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the message table with directed and random operations under random
// idling on both sides and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   item_count;
    bit   no_idle;

    bmt_in_if  in_ch ();
    bmt_out_if out_ch ();
    bmt_cfg_if cfg_ch ();

    bounded_message_table_with_pinning_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    bmt_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_ch     (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Random stalls on the result side, except during the quiet stretch.
    always @(posedge clk)
        out_ch.ready <= no_idle || ($urandom_range(99) >= 27);

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    // The write strobe stays up until the next item or write replaces it.
    task automatic write_register(input logic [bmt_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Drop valid, wait for every result, then let the table sit idle.
    task automatic drain_table();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Valid stays up after a transfer so items can follow back to back.
    task automatic send_item(input logic [1:0] op, input logic [63:0] id,
                             input logic [31:0] dig, input logic hp,
                             input logic [63:0] par, input logic [1:0] init);
        cfg_ch.valid <= 1'b0;
        while (!no_idle && $urandom_range(99) < 27) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.msg_id <= id;
        in_ch.payload_digest <= dig;
        in_ch.has_parent <= hp;
        in_ch.parent_id <= par;
        in_ch.init_state <= init;
        do @(posedge clk); while (!in_ch.ready);
        item_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random traffic, some with bad initial states, over a small id pool so lookups and marks hit.
    task automatic random_traffic(input int count);
        logic [1:0] op;
        logic [63:0] id;
        logic [31:0] dig;
        for (int i = 0; i < count; i++) begin
            op = 2'($urandom_range(3));
            id = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(23));
            dig = ($urandom_range(3) == 0) ? $urandom() : 32'(id[3:0]);
            send_item(op, id, dig, 1'($urandom_range(1)),
                      ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(23)),
                      ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cycle_count = 0;
        item_count = 0;
        no_idle = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = bmt_pkg::OP_INS_RX;
        in_ch.msg_id = '0;
        in_ch.payload_digest = '0;
        in_ch.has_parent = 1'b0;
        in_ch.parent_id = '0;
        in_ch.init_state = bmt_pkg::DL_QUEUED;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bmt_pkg::CFG_CAPACITY;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation, duplicates, conflicts, bad states, marks.
        send_item(bmt_pkg::OP_INS_RX, 64'd0, 32'd0, 1'b1, '1, 2'd3);
        send_item(bmt_pkg::OP_INS_RX, 64'd0, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_RX, 64'd0, '1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_LOCAL, '1, '1, 1'b1, 64'd0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_LOCAL, 64'd5, 32'd5, 1'b0, '0, 2'd3);
        send_item(bmt_pkg::OP_INS_LOCAL, 64'd6, 32'd6, 1'b0, '0, bmt_pkg::DL_BROADCAST);
        send_item(bmt_pkg::OP_INS_LOCAL, 64'd7, 32'd7, 1'b0, '0, bmt_pkg::DL_FAILED);
        send_item(bmt_pkg::OP_MARK_BC, '1, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_MARK_BC, '1, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_MARK_FAIL, '1, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_MARK_FAIL, 64'd0, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_MARK_FAIL, 64'd99, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_MARK_BC, 64'd7, 32'd0, 1'b0, '0, bmt_pkg::DL_QUEUED);
        drain_table();

        // Small table: queue limit, pinned parent, full, then order exhaustion.
        write_register(bmt_pkg::CFG_CAPACITY, 64'd2);
        write_register(bmt_pkg::CFG_QUEUED_LIMIT, 64'd16);
        write_register(bmt_pkg::CFG_START_ORDER, 64'hFFFF_FFFF_FFFF_FFFC);
        send_item(bmt_pkg::OP_INS_LOCAL, 64'd10, 32'd1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_LOCAL, 64'd11, 32'd1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_RX, 64'd12, 32'd1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_LOCAL, 64'd13, 32'd1, 1'b1, 64'd12, bmt_pkg::DL_BROADCAST);
        send_item(bmt_pkg::OP_INS_RX, 64'd14, 32'd1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_RX, 64'd15, 32'd1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        send_item(bmt_pkg::OP_INS_RX, 64'd16, 32'd1, 1'b0, '0, bmt_pkg::DL_QUEUED);
        drain_table();

        // Random phases over several settings, extremes included.
        write_register(bmt_pkg::CFG_START_ORDER, 64'd0);
        write_register(bmt_pkg::CFG_CAPACITY, 64'd0);
        write_register(bmt_pkg::CFG_QUEUED_LIMIT, 64'd0);
        random_traffic(100);
        drain_table();
        write_register(bmt_pkg::CFG_CAPACITY, 64'd31);
        write_register(bmt_pkg::CFG_QUEUED_LIMIT, 64'd31);
        random_traffic(300);
        drain_table();
        write_register(bmt_pkg::CFG_CAPACITY, 64'd3);
        write_register(bmt_pkg::CFG_QUEUED_LIMIT, 64'd1);
        no_idle = 1'b1;
        random_traffic(200);
        no_idle = 1'b0;
        drain_table();
        write_register(bmt_pkg::CFG_CAPACITY, 64'd8);
        write_register(bmt_pkg::CFG_QUEUED_LIMIT, 64'd4);
        write_register(bmt_pkg::CFG_START_ORDER, 64'hFFFF_FFFF_FFFF_FF80);
        random_traffic(300);
        drain_table();
        write_register(bmt_pkg::CFG_CAPACITY, 64'd16);
        write_register(bmt_pkg::CFG_QUEUED_LIMIT, 64'd5);
        random_traffic(230);
        drain_table();

        $display("Covered %0d operations over table sizes 1 to 16, queue limits 0 to 16,",
                 item_count);
        $display("order exhaustion and random stalls on both channels.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- bounded_message_table_with_pinning_top.f -----
rtl/bmt_pkg.sv
rtl/bmt_if.sv
rtl/bmt_ram.sv
rtl/bmt_ctrl.sv
rtl/bmt_dp.sv
rtl/bounded_message_table_with_pinning_top.sv
dv/bmt_checker.sv
dv/testbench.sv
